// ===== hdl/dcma_pkg.sv =====
// ----------------------------------------------------------------------------
// dcma_pkg: shared constants and types for the dual channel moving average
// Default window geometry, result format and the lane control bundle.
// ----------------------------------------------------------------------------
package dcma_pkg;

  localparam int DEF_WINDOW_DEPTH = 8;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int MEAN_W       = 24;
  localparam int FRAC_W       = 8;
  localparam int HELD_W       = 4;
  localparam int HELD_MAX     = 15;
  localparam int RADIX_BITS   = 4;
  localparam int MEAN_MAX     = 8388607;
  localparam int MEAN_MIN_MAG = 8388608;

  typedef struct packed {
    logic start;
    logic ack;
    logic full;
  } dcma_ctl_t;

endpackage

// ===== hdl/dcma_lane.sv =====
// ----------------------------------------------------------------------------
// dcma_lane: one channel of the moving average
// Holds the sample window and a running sum, then divides sum * 256 by the
// held count, four quotient bits per cycle, and saturates to the mean format.
// ----------------------------------------------------------------------------
module dcma_lane
  import dcma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dcma_ctl_t                               ctl,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]         slot,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]       cnt,
  input  logic signed [SAMPLE_WIDTH-1:0]          sample,
  output logic                                    done,
  output logic signed [MEAN_W-1:0]                mean
);

  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
  localparam int DVD_W   = SUM_W + FRAC_W;
  localparam int STEPS   = (DVD_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DVD_P   = STEPS * RADIX_BITS;
  localparam int STEP_W  = $clog2(STEPS) + 1;
  localparam int CMP_W   = (DVD_P > MEAN_W) ? DVD_P : MEAN_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_DEPTH];

  logic [2:0]                     state_r;
  logic [2:0]                     state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] old_r;
  logic signed [SAMPLE_WIDTH-1:0] new_r;
  logic                           full_r;
  logic [CNT_W-1:0]               cnt_r;
  logic signed [SUM_W-1:0]        sum_r;
  logic                           neg_r;
  logic [CNT_W-1:0]               rem_r;
  logic [CNT_W-1:0]               rem_nxt;
  logic [DVD_P-1:0]               dq_r;
  logic [DVD_P-1:0]               dq_nxt;
  logic [STEP_W-1:0]              step_r;
  logic signed [MEAN_W-1:0]       mean_r;
  logic signed [MEAN_W-1:0]       mean_nxt;

  logic signed [SUM_W-1:0]        new_ext;
  logic signed [SUM_W-1:0]        old_ext;
  logic signed [SUM_W-1:0]        sum_nxt;
  logic [SUM_W-1:0]               sum_mag;
  logic [CNT_W:0]                 div_trial;
  logic [CMP_W-1:0]               q_ext;
  logic [CMP_W-1:0]               q_neg;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && ctl.start) begin
      mem[slot] <= sample;
      old_r     <= mem[slot];
      new_r     <= sample;
      full_r    <= ctl.full;
      cnt_r     <= cnt;
    end
  end

  assign new_ext = SUM_W'(new_r);
  assign old_ext = full_r ? SUM_W'(old_r) : '0;
  assign sum_nxt = sum_r + new_ext - old_ext;
  assign sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    div_trial = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      div_trial = {rem_nxt, dq_nxt[DVD_P-1]};
      dq_nxt    = {dq_nxt[DVD_P-2:0], 1'b0};
      if (div_trial >= {1'b0, cnt_r}) begin
        rem_nxt   = CNT_W'(div_trial - {1'b0, cnt_r});
        dq_nxt[0] = 1'b1;
      end else begin
        rem_nxt = CNT_W'(div_trial);
      end
    end
  end

  assign q_ext = CMP_W'(dq_r);
  assign q_neg = -q_ext;

  always_comb begin
    if (!neg_r) begin
      if (q_ext > CMP_W'(MEAN_MAX)) begin
        mean_nxt = MEAN_W'(MEAN_MAX);
      end else begin
        mean_nxt = q_ext[MEAN_W-1:0];
      end
    end else begin
      if (q_ext > CMP_W'(MEAN_MIN_MAG)) begin
        mean_nxt = MEAN_W'(MEAN_MIN_MAG);
      end else begin
        mean_nxt = q_neg[MEAN_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM:  state_nxt = S_DIV;
      S_DIV: begin
        if (step_r == '0) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT:  state_nxt = S_DONE;
      S_DONE: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SUM) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_SUM: begin
        neg_r  <= sum_nxt[SUM_W-1];
        dq_r   <= DVD_P'({sum_mag, {FRAC_W{1'b0}}});
        rem_r  <= '0;
        step_r <= STEP_W'(STEPS - 1);
      end
      S_DIV: begin
        dq_r   <= dq_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
      end
      S_SAT: begin
        mean_r <= mean_nxt;
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == S_DONE);
  assign mean = mean_r;

endmodule

// ===== hdl/dual_channel_moving_average.sv =====
// ----------------------------------------------------------------------------
// dual_channel_moving_average: moving average of left and right speed
// Each input transaction carries one signed speed per channel; each result
// transaction carries both means (8 fraction bits) and the held sample count.
//
// Input channel in_valid/in_ready, result channel out_valid/out_ready. One
// result transaction follows every input transaction, in order.
// Both lanes run in lock step: the running sum is updated in the cycle after
// the input is accepted, then the divider produces four quotient bits per
// cycle, followed by a saturation step. out_valid rises once both lanes are
// done and the output register is free or being emptied.
// in_ready is low while an item is in the lanes. A result waiting in the
// output register does not block the next input; if the receiver still
// stalls when the next result is ready, the lanes hold it until out_ready.
// Reset empties the window (count and write slot to zero) and drops any
// pending result; window contents need no clearing.
// ----------------------------------------------------------------------------
module dual_channel_moving_average
  import dcma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_speed,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_speed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [MEAN_W-1:0]       out_left_mean,
  output logic signed [MEAN_W-1:0]       out_right_mean,
  output logic [HELD_W-1:0]              out_held_count
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int EXT_W  = CNT_W + HELD_W;

  logic [CNT_W-1:0]         fill_r;
  logic [ADDR_W-1:0]        slot_r;
  logic                     busy_r;
  logic                     out_valid_r;
  logic signed [MEAN_W-1:0] left_mean_r;
  logic signed [MEAN_W-1:0] right_mean_r;
  logic [HELD_W-1:0]        held_r;

  dcma_ctl_t                ctl;
  logic                     in_xfer;
  logic                     full;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     left_done;
  logic                     right_done;
  logic signed [MEAN_W-1:0] left_mean;
  logic signed [MEAN_W-1:0] right_mean;
  logic [EXT_W-1:0]         fill_ext;
  logic [HELD_W-1:0]        held_nxt;

  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && in_ready;
  assign full     = (fill_r == CNT_W'(WINDOW_DEPTH));
  assign cnt_nxt  = full ? fill_r : fill_r + 1'b1;

  assign ctl.start = in_xfer;
  assign ctl.full  = full;
  assign ctl.ack   = left_done && right_done && (!out_valid_r || out_ready);

  dcma_lane #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .slot   (slot_r),
    .cnt    (cnt_nxt),
    .sample (in_left_speed),
    .done   (left_done),
    .mean   (left_mean)
  );

  dcma_lane #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .slot   (slot_r),
    .cnt    (cnt_nxt),
    .sample (in_right_speed),
    .done   (right_done),
    .mean   (right_mean)
  );

  assign fill_ext = EXT_W'(fill_r);
  assign held_nxt = (fill_ext > EXT_W'(HELD_MAX)) ? HELD_W'(HELD_MAX) : fill_ext[HELD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      slot_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
        fill_r <= cnt_nxt;
        if (slot_r == ADDR_W'(WINDOW_DEPTH - 1)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
      if (ctl.ack) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ack) begin
      left_mean_r  <= left_mean;
      right_mean_r <= right_mean;
      held_r       <= held_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_mean  = left_mean_r;
  assign out_right_mean = right_mean_r;
  assign out_held_count = held_r;

endmodule

// ===== tb/sv/dual_channel_moving_average_test.sv =====
// ----------------------------------------------------------------------------
// dual_channel_moving_average_test: self-checking bench for the speed smoother
// A directed table walks the window through reset, full-scale samples, wrap
// and rounding toward zero. Random speed pairs follow under random idling on
// both channels. Every result transaction is checked: typed table rows against
// their expected means, all others against a local window-mean predictor.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_test;
  import dcma_pkg::*;

  localparam int SW          = DEF_SAMPLE_WIDTH;
  localparam int DEPTH       = DEF_WINDOW_DEPTH;
  localparam int RANDOM_ITEMS = 1680;
  localparam int CYCLE_LIMIT = 900000;
  localparam int TABLE_ROWS  = 23;

  typedef struct packed {
    logic signed [MEAN_W-1:0] left_mean;
    logic signed [MEAN_W-1:0] right_mean;
    logic [HELD_W-1:0]        held_count;
  } mean_result_t;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    bit                   typed;
    mean_result_t         want;
  } speed_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [SW-1:0]     in_left_speed;
  logic signed [SW-1:0]     in_right_speed;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [MEAN_W-1:0] out_left_mean;
  logic signed [MEAN_W-1:0] out_right_mean;
  logic [HELD_W-1:0]        out_held_count;

  logic signed [SW-1:0] left_hist [DEPTH];
  logic signed [SW-1:0] right_hist [DEPTH];
  int unsigned          hist_fill;
  int unsigned          hist_slot;
  mean_result_t         pending_means [$];
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          ready_hold = 0;
  bit                   steady = 1'b0;

  speed_row_t speed_table [TABLE_ROWS] = '{
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd1}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd2}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd3}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd4}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd5}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd6}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd7}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd8}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{24'sh7FFF00, 24'sh800000, 4'd8}},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'shFFFF, 16'sh0001, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b0, '0},
    '{16'sh0001, 16'shFFFF, 1'b0, '0},
    '{16'shFFFD, 16'sh0005, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 1'b0, '0},
    '{16'shAAAA, 16'sh5555, 1'b0, '0}
  };

  dual_channel_moving_average uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_speed  (in_left_speed),
    .in_right_speed (in_right_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_mean  (out_left_mean),
    .out_right_mean (out_right_mean),
    .out_held_count (out_held_count)
  );

  always #6 clk = ~clk;

  function automatic logic signed [MEAN_W-1:0] scaled_mean(input longint sum,
                                                           input int unsigned count);
    longint q;
    q = (sum * (longint'(1) <<< FRAC_W)) / longint'(count);
    if (q > MEAN_MAX) q = MEAN_MAX;
    if (q < -longint'(MEAN_MIN_MAG)) q = -longint'(MEAN_MIN_MAG);
    return q[MEAN_W-1:0];
  endfunction

  function automatic mean_result_t advance_window(input logic signed [SW-1:0] left,
                                                  input logic signed [SW-1:0] right);
    mean_result_t res;
    longint       left_sum;
    longint       right_sum;
    left_sum = 0;
    right_sum = 0;
    left_hist[hist_slot] = left;
    right_hist[hist_slot] = right;
    hist_slot = (hist_slot + 1) % DEPTH;
    if (hist_fill < DEPTH) hist_fill++;
    for (int i = 0; i < hist_fill; i++) begin
      left_sum += left_hist[i];
      right_sum += right_hist[i];
    end
    res.left_mean = scaled_mean(left_sum, hist_fill);
    res.right_mean = scaled_mean(right_sum, hist_fill);
    res.held_count = (hist_fill > HELD_MAX) ? HELD_MAX[HELD_W-1:0] : hist_fill[HELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic signed [SW-1:0] pick_speed();
    logic signed [SW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = SW'($urandom);
      6:       v = SW'($signed($urandom_range(0, 16)) - 8);
      7:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      8:       v = $urandom_range(0, 1) ? SW'(16'sh7FFF - $urandom_range(0, 7))
                                        : SW'(16'sh8000 + $urandom_range(0, 7));
      default: v = SW'(-$signed($urandom_range(1, 3)));
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_speeds(input logic signed [SW-1:0] left,
                             input logic signed [SW-1:0] right,
                             input bit typed, input mean_result_t typed_want,
                             input int unsigned gap);
    mean_result_t predicted;
    in_valid <= 1'b1;
    in_left_speed <= left;
    in_right_speed <= right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_window(left, right);
    pending_means.push_back(typed ? typed_want : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    mean_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        report_mismatch("unexpected transaction", out_left_mean, 0);
      end else begin
        want = pending_means.pop_front();
        if (out_left_mean !== want.left_mean)
          report_mismatch("left_mean", out_left_mean, want.left_mean);
        if (out_right_mean !== want.right_mean)
          report_mismatch("right_mean", out_right_mean, want.right_mean);
        if (out_held_count !== want.held_count)
          report_mismatch("held_count", out_held_count, want.held_count);
      end
    end
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_ready <= 1'b1;
          ready_hold <= $urandom_range(0, 8);
        end
        6, 7, 8: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(0, 3);
        end
        default: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mean_result_t no_want;
    no_want = '0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_left_speed = '0;
    in_right_speed = '0;
    hist_fill = 0;
    hist_slot = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (speed_table[i])
      send_speeds(speed_table[i].left, speed_table[i].right, speed_table[i].typed,
                  speed_table[i].want, pick_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      send_speeds(pick_speed(), pick_speed(), 1'b0, no_want, pick_gap());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_means.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
